FILE: sv/sepf_pkg.sv
// Shared types, constants and helpers of the stream extremum pair finder.
// No dependencies; every other file of the block imports this package.
package sepf_pkg;

    localparam int SAMPLE_W = 32;

    // saturating item counters since the last rise and the last fall
    localparam logic [1:0] CNT_TOP = 2'd3;
    localparam logic [1:0] CNT_HIT = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample x;
        t_sample y;
    } t_point;

    typedef struct packed {
        t_point lo;
        t_point hi;
        logic   both;
    } t_result;

    function automatic logic [1:0] sat_bump(input logic [1:0] c);
        return (c == CNT_TOP) ? CNT_TOP : c + 2'd1;
    endfunction

endpackage

FILE: sv/sepf_in_stage.sv
// Input register of the stream extremum pair finder: one point transaction.
// Depends on sepf_pkg.
module sepf_in_stage
    import sepf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_sample i_x,
    input  t_sample i_y,
    input  logic    i_last,
    input  logic    i_advance,
    output logic    o_valid,
    output t_sample o_x,
    output t_sample o_y,
    output logic    o_last
);

    logic    r_valid;
    t_sample r_x;
    t_sample r_y;
    logic    r_last;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x    <= i_x;
            r_y    <= i_y;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_last  = r_last;

endmodule

FILE: sv/sepf_core.sv
// Search state of the stream extremum pair finder: window, counters, extrema.
// Depends on sepf_pkg. Produces the result of a last point combinationally.
module sepf_core
    import sepf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_x,
    input  t_sample i_y,
    input  logic    i_last,
    output t_result o_res
);

    localparam logic [1:0] PTS_NONE = 2'd0;
    localparam logic [1:0] PTS_ONE  = 2'd1;
    localparam logic [1:0] PTS_TWO  = 2'd2;

    t_point     r_win_old, n_win_old;
    t_point     r_win_new, n_win_new;
    logic [1:0] r_points, n_points;
    t_point     r_ser_min, n_ser_min;
    t_point     r_ser_max, n_ser_max;
    t_point     r_ext_min, n_ext_min;
    t_point     r_ext_max, n_ext_max;
    logic [1:0] r_fall_cnt, n_fall_cnt;
    logic [1:0] r_rise_cnt, n_rise_cnt;
    logic       r_min_found, n_min_found;
    logic       r_max_found, n_max_found;
    logic       r_done, n_done;

    t_point cur;
    logic   rise;
    logic   fall;

    assign cur  = '{x: i_x, y: i_y};
    assign rise = (r_win_old.y < r_win_new.y) && (r_win_new.y < i_y);
    assign fall = (r_win_new.y < r_win_old.y) && (i_y < r_win_new.y);

    always_comb begin
        n_win_old   = r_win_old;
        n_win_new   = r_win_new;
        n_points    = r_points;
        n_ser_min   = r_ser_min;
        n_ser_max   = r_ser_max;
        n_ext_min   = r_ext_min;
        n_ext_max   = r_ext_max;
        n_fall_cnt  = r_fall_cnt;
        n_rise_cnt  = r_rise_cnt;
        n_min_found = r_min_found;
        n_max_found = r_max_found;
        n_done      = r_done;

        if (i_step && !r_done) begin
            case (r_points)
                PTS_NONE: begin
                    n_ser_min = cur;
                    n_ser_max = cur;
                    n_win_old = r_win_new;
                    n_win_new = cur;
                    n_points  = PTS_ONE;
                end
                PTS_ONE: begin
                    if (i_y < r_ser_min.y) n_ser_min = cur;
                    if (r_ser_max.y < i_y) n_ser_max = cur;
                    n_win_old = r_win_new;
                    n_win_new = cur;
                    n_points  = PTS_TWO;
                end
                default: begin
                    if (rise) begin
                        if (!r_min_found && r_fall_cnt == CNT_HIT) begin
                            n_ext_min   = r_win_old;
                            n_min_found = 1'b1;
                        end
                        n_rise_cnt  = 2'd0;
                        n_max_found = r_max_found && n_min_found;
                    end else if (fall) begin
                        if (!r_max_found && r_rise_cnt == CNT_HIT) begin
                            n_ext_max   = r_win_old;
                            n_max_found = 1'b1;
                        end
                        n_fall_cnt  = 2'd0;
                        n_min_found = r_min_found && n_max_found;
                    end
                    if (n_min_found && n_max_found) begin
                        n_done = 1'b1;
                    end else begin
                        n_fall_cnt = sat_bump(n_fall_cnt);
                        n_rise_cnt = sat_bump(n_rise_cnt);
                        n_win_old  = r_win_new;
                        n_win_new  = cur;
                        if (i_y < r_ser_min.y) n_ser_min = cur;
                        if (r_ser_max.y < i_y) n_ser_max = cur;
                    end
                end
            endcase
        end

        // result of this point, taken before the end-of-series clear
        o_res.both = n_min_found && n_max_found;
        o_res.lo   = o_res.both ? n_ext_min : n_ser_min;
        o_res.hi   = o_res.both ? n_ext_max : n_ser_max;

        if (i_step && i_last) begin
            n_win_old   = '0;
            n_win_new   = '0;
            n_points    = PTS_NONE;
            n_ser_min   = '0;
            n_ser_max   = '0;
            n_ext_min   = '0;
            n_ext_max   = '0;
            n_fall_cnt  = CNT_TOP;
            n_rise_cnt  = CNT_TOP;
            n_min_found = 1'b0;
            n_max_found = 1'b0;
            n_done      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_old   <= '0;
            r_win_new   <= '0;
            r_points    <= PTS_NONE;
            r_ser_min   <= '0;
            r_ser_max   <= '0;
            r_ext_min   <= '0;
            r_ext_max   <= '0;
            r_fall_cnt  <= CNT_TOP;
            r_rise_cnt  <= CNT_TOP;
            r_min_found <= 1'b0;
            r_max_found <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_win_old   <= n_win_old;
            r_win_new   <= n_win_new;
            r_points    <= n_points;
            r_ser_min   <= n_ser_min;
            r_ser_max   <= n_ser_max;
            r_ext_min   <= n_ext_min;
            r_ext_max   <= n_ext_max;
            r_fall_cnt  <= n_fall_cnt;
            r_rise_cnt  <= n_rise_cnt;
            r_min_found <= n_min_found;
            r_max_found <= n_max_found;
            r_done      <= n_done;
        end
    end

    a_done_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_min_found && r_max_found))
        else $error("search frozen without both extrema");

    a_points_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_points != 2'd3)
        else $error("point count beyond two");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_points == PTS_NONE && !r_done && !r_min_found
                                && r_fall_cnt == CNT_TOP))
        else $error("state not cleared after last point");

    a_frozen_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(i_step && i_last)) |=> ($stable(r_win_new) && $stable(r_ser_min)))
        else $error("state moved after search froze");

endmodule

FILE: sv/sepf_out_stage.sv
// Result register of the stream extremum pair finder.
// Depends on sepf_pkg.
module sepf_out_stage
    import sepf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: sv/stream_extremum_pair_finder.sv
// Top level of the stream extremum pair finder.
// Depends on sepf_pkg, sepf_in_stage, sepf_core and sepf_out_stage.
//
// Usage:
//   Input channel (i_valid / o_ready): one (x, y) point per transaction,
//   i_last_item marks the final point of a series. Output channel
//   (o_valid / i_ready): one transaction per series, issued for the last
//   point only, carrying the found minimum and maximum (o_both_found = 1)
//   or the series minimum and maximum (o_both_found = 0, ties keep the
//   earlier point).
//   Path: a last point passes the input register, then the result
//   register, before its result shows on the output channel.
//   Throughput: one point per cycle while no last point is stalled. The
//   search state is updated in the cycle a point leaves the input
//   register; all comparisons are 32-bit compares in that one stage.
//   Stall: a non-last point never waits on the receiver. A last point
//   waits in the input register while the result register holds an
//   untaken result, and o_ready then drops.
//   Reset (synchronous, i_rst_n low): both registers empty, search state
//   at its start values. The state also clears itself after each last point.
module stream_extremum_pair_finder
    import sepf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_sample i_x_sample,
    input  t_sample i_y_sample,
    input  logic    i_last_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_sample o_x_at_minimum,
    output t_sample o_y_at_minimum,
    output t_sample o_x_at_maximum,
    output t_sample o_y_at_maximum,
    output logic    o_both_found
);

    logic    st_valid;
    t_sample st_x;
    t_sample st_y;
    logic    st_last;
    logic    out_can_load;
    logic    advance;
    t_result core_res;
    t_result out_res;

    // a point moves on unless it is last and the result register is busy
    assign advance = st_valid && (!st_last || out_can_load);

    sepf_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_x       (i_x_sample),
        .i_y       (i_y_sample),
        .i_last    (i_last_item),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_x       (st_x),
        .o_y       (st_y),
        .o_last    (st_last)
    );

    sepf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_x     (st_x),
        .i_y     (st_y),
        .i_last  (st_last),
        .o_res   (core_res)
    );

    sepf_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && st_last),
        .i_res      (core_res),
        .o_can_load (out_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_x_at_minimum = out_res.lo.x;
    assign o_y_at_minimum = out_res.lo.y;
    assign o_x_at_maximum = out_res.hi.x;
    assign o_y_at_maximum = out_res.hi.y;
    assign o_both_found   = out_res.both;

endmodule

FILE: bench/stream_extremum_pair_finder_tb.sv
// Self-checking testbench of stream_extremum_pair_finder: directed table, then random series.
// Depends on sepf_pkg and the block's RTL; no files, no arguments.
`timescale 1ns / 1ps

module stream_extremum_pair_finder_tb;
    import sepf_pkg::*;

    localparam int DIR_ROWS      = 25;
    localparam int RANDOM_POINTS = 1700;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int STALL_LIMIT   = 3000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES  = 8;     // settle margin after the final drain
    localparam int PRINT_CAP     = 40;

    localparam t_sample S_MIN = 32'sh8000_0000;
    localparam t_sample S_MAX = 32'sh7fff_ffff;

    // random series shapes
    typedef enum int {
        SHAPE_WAVE,          // strictly monotonic runs, sometimes flat steps
        SHAPE_WIDE_NOISE,    // full-range ordinates
        SHAPE_NARROW_NOISE,  // ordinates in -1..2, lots of ties
        SHAPE_SHORT          // one or two points
    } t_shape;

    // one row of the directed table; want is used only where has_want is set
    typedef struct packed {
        t_sample x;
        t_sample y;
        logic    last;
        logic    has_want;
        t_result want;
    } t_row;

    // ---------------------------------------------------------------- DUT I/O
    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_sample i_x_sample;
    t_sample i_y_sample;
    logic    i_last_item;
    logic    o_valid;
    logic    i_ready;
    t_sample o_x_at_minimum;
    t_sample o_y_at_minimum;
    t_sample o_x_at_maximum;
    t_sample o_y_at_maximum;
    logic    o_both_found;

    // side band driven together with the payload: hand-typed expectation
    logic    drv_has_want;
    t_result drv_want;

    stream_extremum_pair_finder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_x_sample     (i_x_sample),
        .i_y_sample     (i_y_sample),
        .i_last_item    (i_last_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_x_at_minimum (o_x_at_minimum),
        .o_y_at_minimum (o_y_at_minimum),
        .o_x_at_maximum (o_x_at_maximum),
        .o_y_at_maximum (o_y_at_maximum),
        .o_both_found   (o_both_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------- search model
    // Three-point window: win_old is the point two back, win_new the previous one.
    t_point     win_old, win_new;
    logic [1:0] pts_taken;        // saturates at 2
    t_point     run_lo, run_hi;   // running series min / max, ties keep the earlier
    t_point     ext_lo, ext_hi;   // extrema found by the window search
    logic [1:0] n_since_fall, n_since_rise;
    logic       got_min, got_max, frozen;

    t_result pending_extrema[$];  // one entry per last point accepted

    int n_points, n_series, n_results, n_both, n_fallback, n_mismatch;
    int stall_cycles;

    function automatic bit below(t_sample a, t_sample b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic void clear_search();
        win_old      = '0;
        win_new      = '0;
        pts_taken    = 2'd0;
        run_lo       = '0;
        run_hi       = '0;
        ext_lo       = '0;
        ext_hi       = '0;
        n_since_fall = CNT_TOP;
        n_since_rise = CNT_TOP;
        got_min      = 1'b0;
        got_max      = 1'b0;
        frozen       = 1'b0;
    endfunction

    // Advances the search by one point; returns 1 with the result on a last point.
    function automatic bit track_extrema(input t_point p, input logic last,
                                         output t_result res);
        t_sample y_old, y_mid;
        logic    both;
        res = '0;
        if (!frozen) begin
            if (pts_taken == 2'd0) begin
                run_lo    = p;
                run_hi    = p;
                win_old   = win_new;
                win_new   = p;
                pts_taken = 2'd1;
            end else begin
                if (pts_taken == 2'd2) begin
                    y_old = win_old.y;
                    y_mid = win_new.y;
                    if (below(y_old, y_mid) && below(y_mid, p.y)) begin
                        // rising through the window: the old point may be a minimum
                        if (!got_min && n_since_fall == CNT_HIT) begin
                            ext_lo  = win_old;
                            got_min = 1'b1;
                        end
                        n_since_rise = 2'd0;
                        got_max      = got_max && got_min;
                    end else if (below(y_mid, y_old) && below(p.y, y_mid)) begin
                        if (!got_max && n_since_rise == CNT_HIT) begin
                            ext_hi  = win_old;
                            got_max = 1'b1;
                        end
                        n_since_fall = 2'd0;
                        got_min      = got_min && got_max;
                    end
                    frozen = got_min && got_max;
                    if (!frozen) begin
                        if (n_since_fall != CNT_TOP) n_since_fall++;
                        if (n_since_rise != CNT_TOP) n_since_rise++;
                    end
                end
                // the point that completes the pair is not taken into the window
                if (!frozen) begin
                    win_old   = win_new;
                    win_new   = p;
                    pts_taken = 2'd2;
                    if (below(p.y, run_lo.y)) run_lo = p;
                    if (below(run_hi.y, p.y)) run_hi = p;
                end
            end
        end
        if (!last) return 1'b0;
        both     = got_min && got_max;
        res.lo   = both ? ext_lo : run_lo;
        res.hi   = both ? ext_hi : run_hi;
        res.both = both;
        clear_search();
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, t_sample got, t_sample want);
        n_mismatch++;
        if (n_mismatch <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------- monitors
    // Output side is checked before the input side feeds the model, so the
    // expectation queue is touched in a fixed order within a time step.
    always @(posedge i_clk) begin
        t_result want, predicted;
        t_point  pt;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_results++;
                if (pending_extrema.size() == 0) begin
                    report_mismatch("unexpected result transaction", o_y_at_minimum, '0);
                end else begin
                    want = pending_extrema.pop_front();
                    if (o_x_at_minimum != want.lo.x)
                        report_mismatch("x_at_minimum", o_x_at_minimum, want.lo.x);
                    if (o_y_at_minimum != want.lo.y)
                        report_mismatch("y_at_minimum", o_y_at_minimum, want.lo.y);
                    if (o_x_at_maximum != want.hi.x)
                        report_mismatch("x_at_maximum", o_x_at_maximum, want.hi.x);
                    if (o_y_at_maximum != want.hi.y)
                        report_mismatch("y_at_maximum", o_y_at_maximum, want.hi.y);
                    if (o_both_found !== want.both)
                        report_mismatch("both_found", t_sample'(o_both_found),
                                        t_sample'(want.both));
                    if (want.both) n_both++;
                    else n_fallback++;
                end
            end
            if (i_valid && o_ready) begin
                n_points++;
                pt.x = i_x_sample;
                pt.y = i_y_sample;
                if (track_extrema(pt, i_last_item, predicted)) begin
                    n_series++;
                    pending_extrema.push_back(drv_has_want ? drv_want : predicted);
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
        else stall_cycles++;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL stream_extremum_pair_finder");
        $finish;
    end

    // ------------------------------------------------------------- receiver
    // Random back-pressure in phases; a hold request from the sender makes it
    // refuse results through a long hold-off so the block fills and stalls.
    int hold_asks, holds_done, hold_left, rx_pause, rx_cycle;
    bit rx_idle_on = 1'b1;

    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_asks != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else if (rx_pause != 0) begin
            rx_pause--;
            i_ready <= 1'b0;
        end else if (!rx_idle_on || $urandom_range(0, 99) < 75) begin
            i_ready <= 1'b1;
        end else begin
            rx_pause = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            i_ready <= 1'b0;
        end
    end

    // --------------------------------------------------------------- sender
    bit tx_idle_on = 1'b1;
    int n_offered;

    // Offers one point and holds it until the transaction; valid stays high
    // unless a gap follows.
    task automatic offer_point(t_sample x, t_sample y, logic last,
                               logic has_want, t_result want);
        int gap;
        i_valid      <= 1'b1;
        i_x_sample   <= x;
        i_y_sample   <= y;
        i_last_item  <= last;
        drv_has_want <= has_want;
        drv_want     <= want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_offered++;
        if (tx_idle_on && $urandom_range(0, 99) < 30) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_series(t_shape shape);
        int      len, run_left, k;
        t_sample y, step;
        bit      rising;
        case (shape)
            SHAPE_WAVE: begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 80)
                                                    : $urandom_range(3, 24);
            end
            SHAPE_WIDE_NOISE:   len = $urandom_range(1, 12);
            SHAPE_NARROW_NOISE: len = $urandom_range(1, 16);
            default:            len = $urandom_range(1, 2);
        endcase
        y        = $urandom;
        rising   = $urandom_range(0, 1);
        run_left = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
            case (shape)
                SHAPE_WAVE: begin
                    if (k != 0) begin
                        if (run_left == 0) begin
                            rising   = !rising;
                            run_left = $urandom_range(1, 4);
                        end
                        // flat step now and then breaks the strict runs
                        step = ($urandom_range(0, 9) == 0) ? 0
                             : $urandom_range(1, 32'd1 << $urandom_range(0, 24));
                        y = rising ? y + step : y - step;
                        run_left--;
                    end
                end
                SHAPE_NARROW_NOISE: y = t_sample'($urandom_range(0, 3)) - 1;
                default:            y = $urandom;
            endcase
            offer_point($urandom, y, k == len - 1, 1'b0, '0);
        end
    endtask

    // Lowers valid and waits for every expected result to come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_extrema.size() != 0) @(posedge i_clk);
    endtask

    // ----------------------------------------------------------- main flow
    initial begin
        t_row rows [DIR_ROWS];
        int   r, series_no, pick;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_x_sample   <= '0;
        i_y_sample   <= '0;
        i_last_item  <= 1'b0;
        i_ready      <= 1'b0;
        drv_has_want <= 1'b0;
        drv_want     <= '0;
        clear_search();

        // Directed table. Typed expectations only where they are obvious.
        // one-point series at the extremes: the point is both min and max
        rows[0]  = '{S_MIN, S_MAX, 1'b1, 1'b1, '{'{S_MIN, S_MAX}, '{S_MIN, S_MAX}, 1'b0}};
        rows[1]  = '{S_MAX, S_MIN, 1'b1, 1'b1, '{'{S_MAX, S_MIN}, '{S_MAX, S_MIN}, 1'b0}};
        // two-point series: plain min and max of the two
        rows[2]  = '{0, -5, 1'b0, 1'b0, '0};
        rows[3]  = '{1, 7, 1'b1, 1'b1, '{'{0, -5}, '{1, 7}, 1'b0}};
        // two-point tie: the earlier point wins both
        rows[4]  = '{5, 3, 1'b0, 1'b0, '0};
        rows[5]  = '{6, 3, 1'b1, 1'b1, '{'{5, 3}, '{5, 3}, 1'b0}};
        // valley then peak, pair found mid-series, trailing points ignored
        rows[6]  = '{10, 10, 1'b0, 1'b0, '0};
        rows[7]  = '{11, 5, 1'b0, 1'b0, '0};
        rows[8]  = '{12, 0, 1'b0, 1'b0, '0};
        rows[9]  = '{13, 5, 1'b0, 1'b0, '0};
        rows[10] = '{14, 10, 1'b0, 1'b0, '0};
        rows[11] = '{15, 5, 1'b0, 1'b0, '0};
        rows[12] = '{16, 0, 1'b0, 1'b0, '0};
        rows[13] = '{17, 99, 1'b0, 1'b0, '0};
        rows[14] = '{18, -99, 1'b1, 1'b0, '0};
        // same shape at full-scale ordinates, pair completed by the last point
        rows[15] = '{S_MIN, S_MAX, 1'b0, 1'b0, '0};
        rows[16] = '{-1, 0, 1'b0, 1'b0, '0};
        rows[17] = '{0, S_MIN, 1'b0, 1'b0, '0};
        rows[18] = '{1, 0, 1'b0, 1'b0, '0};
        rows[19] = '{S_MAX, S_MAX, 1'b0, 1'b0, '0};
        rows[20] = '{2, 0, 1'b0, 1'b0, '0};
        rows[21] = '{3, S_MIN, 1'b1, 1'b0, '0};
        // flat series: fallback, first point kept on ties
        rows[22] = '{40, 4, 1'b0, 1'b0, '0};
        rows[23] = '{41, 4, 1'b0, 1'b0, '0};
        rows[24] = '{42, 4, 1'b1, 1'b0, '0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIR_ROWS; r++)
            offer_point(rows[r].x, rows[r].y, rows[r].last, rows[r].has_want, rows[r].want);
        drain_results();

        // Random series, mostly waves so the window search gets deep.
        n_offered = 0;
        series_no = 0;
        while (n_offered < RANDOM_POINTS) begin
            series_no++;
            if (series_no == 30) begin
                // receiver holds off; a burst of short series fills the block
                hold_asks  <= hold_asks + 1;
                tx_idle_on = 1'b0;
                repeat (16) send_series(SHAPE_SHORT);
            end else if (series_no == 80) begin
                drain_results();
            end
            tx_idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 60)      send_series(SHAPE_WAVE);
            else if (pick < 75) send_series(SHAPE_WIDE_NOISE);
            else if (pick < 90) send_series(SHAPE_NARROW_NOISE);
            else                send_series(SHAPE_SHORT);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d points in %0d series; %0d results checked",
                 n_points, n_series, n_results);
        $display("%0d with both extrema found, %0d by fallback, %0d mismatches",
                 n_both, n_fallback, n_mismatch);
        if (n_mismatch == 0 && pending_extrema.size() == 0) begin
            $display("PASS stream_extremum_pair_finder");
        end else begin
            $display("FAIL stream_extremum_pair_finder");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sepf_pkg.sv
sv/sepf_in_stage.sv
sv/sepf_core.sv
sv/sepf_out_stage.sv
sv/stream_extremum_pair_finder.sv
bench/stream_extremum_pair_finder_tb.sv
